@@ sv/fcl_pkg.sv @@
// Shared types and constants of the fully connected layer.
package fcl_pkg;

  localparam int unsigned VALUE_W      = 16;
  localparam int unsigned INDEX_W      = 12;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned CFG_W        = 7;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned ACC_W        = 48;
  localparam int unsigned PROD_W       = 2 * VALUE_W;
  localparam int unsigned FRAC_W       = 12;
  localparam int unsigned VEC_DEPTH    = 64;
  localparam int unsigned VEC_AW       = 6;
  localparam int unsigned BIAS_DEPTH   = 64;
  localparam int unsigned BIAS_AW      = 6;
  localparam int unsigned WEIGHT_DEPTH = 4096;
  localparam int unsigned NEURON_W     = 6;

  // Input operation codes
  localparam logic [OP_W-1:0] OP_WEIGHT = 2'd0;
  localparam logic [OP_W-1:0] OP_BIAS   = 2'd1;
  localparam logic [OP_W-1:0] OP_INPUT  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_INPUT_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NEURON_COUNT = 2'd1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                  wt_we;
    logic                  bias_we;
    logic                  vec_we;
    logic                  bias_rd;
    logic                  mac_rd;
    logic [BIAS_AW-1:0]    bias_addr;
    logic [VEC_AW-1:0]     vec_addr;
    logic [INDEX_W-1:0]    wt_addr;
    logic                  emit;
    logic                  zero;
    logic [NEURON_W-1:0]   out_index;
    logic                  out_last;
  } fcl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } fcl_stat_t;

endpackage

@@ sv/fcl_ifs.sv @@
// Word channels of the fully connected layer: input items and results.
interface fcl_in_if
  import fcl_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [INDEX_W-1:0]        index;
  logic signed [VALUE_W-1:0] value;
  logic                      last_element;
  logic                      vector_valid;

  modport source (output valid, operation, index, value, last_element, vector_valid,
                  input ready);
  modport sink   (input valid, operation, index, value, last_element, vector_valid,
                  output ready);
endinterface

interface fcl_out_if
  import fcl_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [NEURON_W-1:0]       neuron_index;
  logic signed [VALUE_W-1:0] neuron_sum;
  logic                      saturated;
  logic                      last_neuron;

  modport source (output valid, neuron_index, neuron_sum, saturated, last_neuron,
                  input ready);
  modport sink   (input valid, neuron_index, neuron_sum, saturated, last_neuron,
                  output ready);
endinterface

@@ sv/fcl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fcl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/fcl_datapath.sv @@
// Table memories, multiply-accumulate pipeline, rounding and result register.
module fcl_datapath
  import fcl_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fcl_cmd_t                  cmd_i,
  input  logic [INDEX_W-1:0]        wr_index_i,
  input  logic signed [VALUE_W-1:0] wr_value_i,
  output fcl_stat_t                 stat_o,
  fcl_out_if.source                 out_if
);

  logic [VALUE_W-1:0] wt_rd, bias_rd, vec_rd;

  fcl_ram #(.WIDTH(VALUE_W), .DEPTH(WEIGHT_DEPTH)) u_wt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wt_we),
    .waddr_i (wr_index_i),
    .wdata_i (wr_value_i),
    .re_i    (cmd_i.mac_rd),
    .raddr_i (cmd_i.wt_addr),
    .rdata_o (wt_rd)
  );

  fcl_ram #(.WIDTH(VALUE_W), .DEPTH(BIAS_DEPTH)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.bias_we),
    .waddr_i (wr_index_i[BIAS_AW-1:0]),
    .wdata_i (wr_value_i),
    .re_i    (cmd_i.bias_rd),
    .raddr_i (cmd_i.bias_addr),
    .rdata_o (bias_rd)
  );

  fcl_ram #(.WIDTH(VALUE_W), .DEPTH(VEC_DEPTH)) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.vec_we),
    .waddr_i (wr_index_i[VEC_AW-1:0]),
    .wdata_i (wr_value_i),
    .re_i    (cmd_i.mac_rd),
    .raddr_i (cmd_i.vec_addr),
    .rdata_o (vec_rd)
  );

  logic                      bias_v_q, mac_v_q, prod_v_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic                      out_valid_q;
  logic [NEURON_W-1:0]       out_index_q;
  logic signed [VALUE_W-1:0] out_sum_q;
  logic                      out_sat_q;
  logic                      out_last_q;

  logic signed [ACC_W-1:0]        rnd;
  logic signed [ACC_W-FRAC_W-1:0] shifted;
  logic signed [VALUE_W-1:0]      sum_d;
  logic                           sat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_v_q <= 1'b0;
      mac_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      bias_v_q <= cmd_i.bias_rd;
      mac_v_q  <= cmd_i.mac_rd;
      prod_v_q <= mac_v_q;
    end
  end

  // product register, then accumulate
  always_ff @(posedge clk_i) begin
    if (mac_v_q) begin
      prod_q <= $signed(vec_rd) * $signed(wt_rd);
    end
    if (bias_v_q) begin
      acc_q <= {{(ACC_W-VALUE_W-FRAC_W){bias_rd[VALUE_W-1]}}, bias_rd, {FRAC_W{1'b0}}};
    end else if (prod_v_q) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // round to nearest, ties up, then saturate; the zero command forces a zero sum
  always_comb begin
    rnd     = acc_q + ACC_W'(2048);
    shifted = rnd[ACC_W-1:FRAC_W];
    sat_d   = 1'b0;
    sum_d   = shifted[VALUE_W-1:0];
    if (shifted > (ACC_W-FRAC_W)'(32767)) begin
      sum_d = 16'sh7fff;
      sat_d = 1'b1;
    end else if (shifted < -(ACC_W-FRAC_W)'(32768)) begin
      sum_d = 16'sh8000;
      sat_d = 1'b1;
    end
    if (cmd_i.zero) begin
      sum_d = '0;
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_index_q <= cmd_i.out_index;
      out_sum_q   <= sum_d;
      out_sat_q   <= sat_d;
      out_last_q  <= cmd_i.out_last;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.neuron_index = out_index_q;
  assign out_if.neuron_sum   = out_sum_q;
  assign out_if.saturated    = out_sat_q;
  assign out_if.last_neuron  = out_last_q;

  assign stat_o.pipe_busy = bias_v_q | mac_v_q | prod_v_q;
  assign stat_o.out_free  = ~out_valid_q | out_if.ready;

endmodule

@@ sv/fcl_ctrl.sv @@
// Sequencer: configuration registers, table writes and neuron/element loops.
module fcl_ctrl
  import fcl_pkg::*;
#(
  parameter int unsigned MAX_INPUTS  = 64,
  parameter int unsigned MAX_NEURONS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [OP_W-1:0]        in_op_i,
  input  logic [INDEX_W-1:0]     in_index_i,
  input  logic                   in_last_i,
  input  logic                   in_vvalid_i,
  input  fcl_stat_t              stat_i,
  output fcl_cmd_t               cmd_o
);

  localparam logic [CFG_W-1:0]   NiMax   = CFG_W'(VEC_DEPTH);
  localparam logic [CFG_W-1:0]   NnMax   = CFG_W'(MAX_NEURONS);
  localparam logic [INDEX_W-1:0] WtStep  = INDEX_W'(MAX_INPUTS);
  localparam logic [INDEX_W-1:0] BiasLim = INDEX_W'(MAX_NEURONS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BIAS,
    S_MAC,
    S_FINISH
  } state_e;

  state_e               state_q;
  logic [CFG_W-1:0]     in_count_q, nr_count_q;
  logic [NEURON_W-1:0]  n_q;
  logic [VEC_AW-1:0]    i_q;
  logic [INDEX_W-1:0]   base_q;
  logic                 vvalid_q;

  logic [CFG_W-1:0] ni_eff, nn_eff;
  logic             accept, start, i_last, n_last;

  assign ni_eff = (in_count_q > NiMax) ? NiMax : in_count_q;
  assign nn_eff = (nr_count_q > NnMax) ? NnMax : nr_count_q;
  assign i_last = ({1'b0, i_q} == ni_eff - CFG_W'(1));
  assign n_last = ({1'b0, n_q} == nn_eff - CFG_W'(1));

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign start      = accept & (in_op_i == OP_INPUT) & in_last_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.wt_we     = accept & (in_op_i == OP_WEIGHT);
    cmd_o.bias_we   = accept & (in_op_i == OP_BIAS) & (in_index_i < BiasLim);
    cmd_o.vec_we    = accept & (in_op_i == OP_INPUT) & (in_index_i < INDEX_W'(VEC_DEPTH));
    cmd_o.bias_rd   = (state_q == S_BIAS);
    cmd_o.mac_rd    = (state_q == S_MAC);
    cmd_o.bias_addr = n_q;
    cmd_o.vec_addr  = i_q;
    cmd_o.wt_addr   = base_q + INDEX_W'(i_q);
    cmd_o.emit      = (state_q == S_FINISH) & ~stat_i.pipe_busy & stat_i.out_free;
    cmd_o.zero      = ~vvalid_q;
    cmd_o.out_index = n_q;
    cmd_o.out_last  = n_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_count_q <= CFG_W'(1);
      nr_count_q <= CFG_W'(1);
      n_q        <= '0;
      i_q        <= '0;
      base_q     <= '0;
      vvalid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_INPUT_COUNT:  in_count_q <= cfg_data_i;
          REG_NEURON_COUNT: nr_count_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            vvalid_q <= in_vvalid_i;
            n_q      <= '0;
            base_q   <= '0;
            if (nn_eff != '0) begin
              state_q <= S_BIAS;
            end
          end
        end
        S_BIAS: begin
          i_q <= '0;
          state_q <= (ni_eff == '0) ? S_FINISH : S_MAC;
        end
        S_MAC: begin
          if (i_last) begin
            state_q <= S_FINISH;
          end else begin
            i_q <= i_q + VEC_AW'(1);
          end
        end
        S_FINISH: begin
          if (cmd_o.emit) begin
            if (n_last) begin
              state_q <= S_IDLE;
            end else begin
              n_q     <= n_q + NEURON_W'(1);
              base_q  <= base_q + WtStep;
              state_q <= S_BIAS;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/fully_connected_layer_top.sv @@
// Top level of the fully connected layer: controller, datapath and ports.
//
// Input channel (in_if): each word either writes one weight (operation 0,
// index = neuron*MAX_INPUTS + position), one bias (operation 1, index =
// neuron) or one input element (operation 2, index = position). An input
// element marked last_element starts the layer: one result word per neuron,
// neuron 0 first, on the output channel (out_if). vector_valid clear on that
// word gives zero sums for every neuron.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 input_count, 1 neuron_count); write only while the block is idle.
// Throughput: table writes and non-last elements are accepted back to back
// while the sequencer is idle. The last element blocks the input until every
// neuron is done: per neuron one bias read, input_count multiply-accumulate
// steps through the single MAC unit (one weight and one element read per
// cycle), a drain of the read/multiply/accumulate pipeline, and rounding into
// the result register.
// Stall: the result register holds its word while out_if.ready is low, and
// the sequencer waits before rounding the next neuron into it.
// Reset: counts return to one; the tables keep their contents, which are
// undefined until written.
module fully_connected_layer_top
  import fcl_pkg::*;
#(
  parameter int unsigned MAX_INPUTS  = 64,
  parameter int unsigned MAX_NEURONS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  fcl_in_if.sink                 in_if,
  fcl_out_if.source              out_if
);

  fcl_cmd_t  cmd;
  fcl_stat_t stat;
  logic      in_ready;

  // sequencer: owns counts, loops and handshake on the input side
  fcl_ctrl #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_NEURONS (MAX_NEURONS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_ready),
    .in_op_i     (in_if.operation),
    .in_index_i  (in_if.index),
    .in_last_i   (in_if.last_element),
    .in_vvalid_i (in_if.vector_valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  assign in_if.ready = in_ready;

  // datapath: tables, MAC pipeline, rounding and the result register
  fcl_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .wr_index_i (in_if.index),
    .wr_value_i (in_if.value),
    .stat_o     (stat),
    .out_if     (out_if)
  );

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the fully connected layer: stimulus, prediction and checks.
`timescale 1ns / 1ps

// Method of checking:
// - A small corner of the tables is preloaded after reset. The bench tracks
//   every entry written, and a vector is only sent as valid when all entries
//   its computation reads have been written; otherwise it goes out invalid.
// - A short directed run follows. It covers saturation both ways, rounding ties,
//   an invalid vector, ignored writes, the unused operation code and last marks
//   on table writes.
// - Randomised phases follow, each under its own pair of count registers, the
//   extremes among them. Each accepted input word updates a private copy of the
//   tables and queues the neuron sums it causes. Each result word is matched
//   against the oldest queued sum.
module testbench
  import fcl_pkg::*;
;

  localparam int MAX_INPUTS  = 64;
  localparam int MAX_NEURONS = 64;

  // Codes the package leaves unnamed: the spare operation and the spare registers
  localparam logic [OP_W-1:0]        OP_UNUSED   = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int QUIET_LIMIT   = 5000;  // cycles with no word moving on either side
  localparam int SETTLE_CYCLES = 80;    // grace after the last sum before a register write
  localparam int HOLD_OFF      = 400;   // long receiver hold-off that backs the block up
  localparam int TAIL_CYCLES   = 100;
  localparam int PHASES        = 8;
  localparam int PRE_NEURONS   = 8;     // neurons whose bias and leading weights are preloaded
  localparam int PRE_SPAN      = 4;     // positions preloaded per neuron and in the vector

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] val;
    logic               last;
    logic               vvalid;
  } layer_item_t;

  typedef struct packed {
    logic [NEURON_W-1:0] neuron;
    logic [VALUE_W-1:0]  level;
    logic                clipped;
    logic                tail;
  } neuron_sum_t;

  // Private copy of the layer: tables, counts, and the sums still owed by the block
  class layer_sum_ledger;
    logic [VALUE_W-1:0] weight_mem [WEIGHT_DEPTH];
    logic [VALUE_W-1:0] bias_mem [BIAS_DEPTH];
    logic [VALUE_W-1:0] elem_mem [VEC_DEPTH];
    bit                 weight_set [WEIGHT_DEPTH];
    bit                 bias_set [BIAS_DEPTH];
    bit                 elem_set [VEC_DEPTH];
    logic [CFG_W-1:0]   inputs_used;
    logic [CFG_W-1:0]   neurons_used;
    neuron_sum_t        sums_owed [$];
    int unsigned        bad_sums;

    function new();
      inputs_used  = 1;
      neurons_used = 1;
      bad_sums     = 0;
    endfunction

    function void set_count(logic [CFG_INDEX_W-1:0] sel, logic [CFG_W-1:0] data);
      if (sel == REG_INPUT_COUNT) inputs_used = data;
      else if (sel == REG_NEURON_COUNT) neurons_used = data;
    endfunction

    function int unsigned pending();
      return sums_owed.size();
    endfunction

    // True when a vector closed by an element at pos reads only written entries
    function bit all_written(logic [INDEX_W-1:0] pos);
      int span, crowd, n, i;
      span  = inputs_used > VEC_DEPTH ? VEC_DEPTH : inputs_used;
      crowd = neurons_used > MAX_NEURONS ? MAX_NEURONS : neurons_used;
      for (n = 0; n < crowd; n++) begin
        if (!bias_set[n]) return 1'b0;
        for (i = 0; i < span; i++)
          if (!weight_set[(n * MAX_INPUTS + i) % WEIGHT_DEPTH] ||
              !(elem_set[i] || pos == INDEX_W'(i)))
            return 1'b0;
      end
      return 1'b1;
    endfunction

    // Q40.24 accumulation of one neuron: bias shifted up plus exact products
    function longint neuron_total(int n, int span);
      longint acc;
      int     i;
      acc = longint'($signed(bias_mem[n])) * 4096;
      for (i = 0; i < span; i++)
        acc += longint'($signed(elem_mem[i])) *
               longint'($signed(weight_mem[(n * MAX_INPUTS + i) % WEIGHT_DEPTH]));
      return acc;
    endfunction

    function void take_item(layer_item_t it);
      int          span, crowd, n;
      longint      q;
      neuron_sum_t w;
      case (it.op)
        OP_WEIGHT: begin
          weight_mem[it.idx] = it.val;
          weight_set[it.idx] = 1'b1;
        end
        OP_BIAS: if (it.idx < BIAS_DEPTH) begin
          bias_mem[it.idx[BIAS_AW-1:0]] = it.val;
          bias_set[it.idx[BIAS_AW-1:0]] = 1'b1;
        end
        OP_INPUT: begin
          if (it.idx < VEC_DEPTH) begin
            elem_mem[it.idx[VEC_AW-1:0]] = it.val;
            elem_set[it.idx[VEC_AW-1:0]] = 1'b1;
          end
          if (it.last) begin
            span  = inputs_used > VEC_DEPTH ? VEC_DEPTH : inputs_used;
            crowd = neurons_used > MAX_NEURONS ? MAX_NEURONS : neurons_used;
            for (n = 0; n < crowd; n++) begin
              w.neuron  = NEURON_W'(n);
              w.level   = '0;
              w.clipped = 1'b0;
              w.tail    = (n == crowd - 1);
              if (it.vvalid) begin
                // round to nearest, ties upward, then clip to Q4.12
                q = (neuron_total(n, span) + 2048) >>> 12;
                if (q > 32767) begin
                  w.level   = 16'h7FFF;
                  w.clipped = 1'b1;
                end else if (q < -32768) begin
                  w.level   = 16'h8000;
                  w.clipped = 1'b1;
                end else begin
                  w.level = q[VALUE_W-1:0];
                end
              end
              sums_owed.push_back(w);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void match_sum(neuron_sum_t got);
      neuron_sum_t want;
      if (sums_owed.size() == 0) begin
        bad_sums++;
        if (bad_sums <= 10)
          $display("%0t: unexpected sum: neuron %0d sum %0d sat %0b last %0b", $realtime,
                   got.neuron, $signed(got.level), got.clipped, got.tail);
        return;
      end
      want = sums_owed.pop_front();
      if (got.neuron !== want.neuron || got.level !== want.level ||
          got.clipped !== want.clipped || got.tail !== want.tail) begin
        bad_sums++;
        if (bad_sums <= 10)
          $display("%0t: sum mismatch: neuron %0d/%0d sum %0d/%0d sat %0b/%0b last %0b/%0b",
                   $realtime, want.neuron, got.neuron, $signed(want.level),
                   $signed(got.level), want.clipped, got.clipped, want.tail, got.tail);
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]       cfg_data_i;

  fcl_in_if  in_ch ();
  fcl_out_if out_ch ();

  layer_sum_ledger sb = new();

  bit tx_idle_on;
  bit rx_idle_on;
  int unsigned hold_off_len;

  int unsigned phase_ni     [PHASES] = '{4, 1, 0, 127, 3, 5, 64, 2};
  int unsigned phase_nn     [PHASES] = '{3, 16, 5, 1, 0, 127, 64, 6};
  int unsigned phase_budget [PHASES] = '{12, 12, 8, 10, 8, 12, 10, 14};

  fully_connected_layer_top #(
    .MAX_INPUTS (MAX_INPUTS),
    .MAX_NEURONS(MAX_NEURONS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly small Q4.12 values so that sums stay in range, with full-scale ones
  // and both extremes mixed in to reach the clipping paths
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return 16'h7FFF;
    if (roll == 1) return 16'h8000;
    if (roll < 6) return VALUE_W'($urandom);
    return VALUE_W'($urandom_range(0, 16'h07FF) - 16'h0400);
  endfunction

  // Offer one input word from the falling edge, optionally after an idle burst,
  // and hold it until the block takes it at a rising edge. A vector that would
  // read a table entry never written goes out invalid.
  task automatic push_word(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                           input logic [VALUE_W-1:0] val, input logic last,
                           input logic vvalid);
    layer_item_t it;
    logic        vv;
    vv = vvalid;
    if (op == OP_INPUT && last && !sb.all_written(idx)) vv = 1'b0;
    it = '{op: op, idx: idx, val: val, last: last, vvalid: vv};
    @(negedge clk_i);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_ch.operation    = op;
    in_ch.index        = idx;
    in_ch.value        = val;
    in_ch.last_element = last;
    in_ch.vector_valid = vv;
    in_ch.valid        = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.take_item(it);
  endtask

  // Drop valid and wait for every owed sum, then give the block a short grace
  // period in case a word that causes no sum is still being worked on
  task automatic await_idle();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count_reg(input logic [CFG_INDEX_W-1:0] sel,
                                 input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = sel;
    cfg_data_i  = data;
    sb.set_count(sel, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Random traffic under the current counts. Half of the choices are
  // well-formed vectors (a few elements within the span, anywhere for an empty
  // span, the last one marked). The rest are table updates and noise: the spare
  // operation, out-of-range positions and biases, and last marks on table writes.
  task automatic run_phase(input int unsigned budget);
    int unsigned done, span, crowd, k, j, roll, pos;
    done  = 0;
    span  = sb.inputs_used > VEC_DEPTH ? VEC_DEPTH : sb.inputs_used;
    crowd = sb.neurons_used > MAX_NEURONS ? MAX_NEURONS : sb.neurons_used;
    while (done < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        k = (span == 0) ? 1 : $urandom_range(1, span < 8 ? span : 8);
        for (j = 0; j < k; j++) begin
          if (span == 0) pos = $urandom_range(0, VEC_DEPTH - 1);
          else if (k == span) pos = j;
          else pos = $urandom_range(0, span - 1);
          push_word(OP_INPUT, INDEX_W'(pos), pick_value(), j == k - 1,
                    $urandom_range(0, 5) != 0);
        end
        done += k;
      end else if (roll < 70) begin
        // aim most weight writes at the region the current counts read
        if (span != 0 && crowd != 0 && $urandom_range(0, 3) != 0)
          pos = $urandom_range(0, crowd - 1) * MAX_INPUTS + $urandom_range(0, span - 1);
        else
          pos = $urandom_range(0, WEIGHT_DEPTH - 1);
        push_word(OP_WEIGHT, INDEX_W'(pos), pick_value(), 1'b0, 1'b1);
        done++;
      end else if (roll < 82) begin
        push_word(OP_BIAS, INDEX_W'($urandom_range(0, BIAS_DEPTH - 1)), pick_value(),
                  1'b0, 1'b1);
        done++;
      end else begin
        case (roll % 4)
          0: push_word(OP_UNUSED, INDEX_W'($urandom), pick_value(), 1'($urandom),
                       1'($urandom));
          1: begin
            k = $urandom_range(0, 1);
            push_word(OP_INPUT, INDEX_W'($urandom_range(VEC_DEPTH, 4095)), pick_value(),
                      k[0], $urandom_range(0, 3) != 0);
            done += k;
          end
          2: begin
            if ($urandom_range(0, 1))
              push_word(OP_WEIGHT, INDEX_W'($urandom), pick_value(), 1'b1, 1'($urandom));
            else
              push_word(OP_BIAS, INDEX_W'($urandom_range(0, BIAS_DEPTH - 1)), pick_value(),
                        1'b1, 1'($urandom));
            done++;
          end
          default: push_word(OP_BIAS, INDEX_W'($urandom_range(BIAS_DEPTH, 4095)),
                             pick_value(), 1'($urandom), 1'b1);
        endcase
      end
    end
  endtask

  // Receiver: ready changes on the falling edge only. Take a pending long
  // hold-off first, else drop ready for a short random burst when idling is on.
  initial begin
    int unsigned n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_off_len != 0) begin
        n = hold_off_len;
        hold_off_len = 0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 10);
      end else begin
        n = 0;
      end
      if (n != 0) begin
        out_ch.ready = 1'b0;
        repeat (n) @(negedge clk_i);
        out_ch.ready = 1'b1;
      end
    end
  end

  // Check every result word as it is taken
  always @(posedge clk_i)
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.match_sum(neuron_sum_t'{out_ch.neuron_index, out_ch.neuron_sum,
                                 out_ch.saturated, out_ch.last_neuron});

  // Watchdog: count cycles in which no word moves on either side
  always @(posedge clk_i) begin
    int unsigned quiet;
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $realtime, quiet);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int i, j, p;
    // Drive every input to a known value from time zero
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = REG_INPUT_COUNT;
    cfg_data_i         = '0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_WEIGHT;
    in_ch.index        = '0;
    in_ch.value        = '0;
    in_ch.last_element = 1'b0;
    in_ch.vector_valid = 1'b0;
    tx_idle_on         = 1'b0;
    rx_idle_on         = 1'b1;
    hold_off_len       = 0;

    // Hold reset, then release it on a falling edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Preload the leading weights and bias of the first few neurons and the
    // first few elements, enough for the small counts to give valid vectors
    for (i = 0; i < PRE_NEURONS; i++) begin
      for (j = 0; j < PRE_SPAN; j++)
        push_word(OP_WEIGHT, INDEX_W'(i * MAX_INPUTS + j), pick_value(), 1'b0, 1'b0);
      push_word(OP_BIAS, INDEX_W'(i), pick_value(), 1'b0, 1'b1);
    end
    for (i = 0; i < PRE_SPAN; i++)
      push_word(OP_INPUT, INDEX_W'(i), pick_value(), 1'b0, 1'b1);

    // Directed words under the reset counts: one input, one neuron
    tx_idle_on = 1'b1;
    push_word(OP_BIAS,   12'd0,   16'h7FFF, 1'b0, 1'b1);
    push_word(OP_WEIGHT, 12'd0,   16'h7FFF, 1'b1, 1'b1);  // last mark ignored on a weight
    push_word(OP_INPUT,  12'd0,   16'h7FFF, 1'b1, 1'b1);  // clips high
    push_word(OP_INPUT,  12'd0,   16'h8000, 1'b1, 1'b1);  // clips low
    push_word(OP_BIAS,   12'd0,   16'h0000, 1'b1, 1'b0);  // last mark ignored on a bias
    push_word(OP_WEIGHT, 12'd0,   16'h0800, 1'b0, 1'b1);
    push_word(OP_INPUT,  12'd0,   16'h0001, 1'b1, 1'b1);  // half-way tie rounds up to 1
    push_word(OP_INPUT,  12'd0,   16'hFFFF, 1'b1, 1'b1);  // negative tie rounds up to 0
    push_word(OP_INPUT,  12'd0,   16'h0003, 1'b1, 1'b1);
    push_word(OP_INPUT,  12'd0,   16'hFFFD, 1'b1, 1'b1);
    push_word(OP_INPUT,  12'd0,   16'h7FFF, 1'b1, 1'b0);  // invalid vector gives zero
    push_word(OP_BIAS,   12'd64,  16'h1234, 1'b0, 1'b1);  // bias beyond the table
    push_word(OP_BIAS,   12'hFFF, 16'h7FFF, 1'b0, 1'b1);
    push_word(OP_INPUT,  12'd64,  16'h7FFF, 1'b0, 1'b1);  // element beyond the table
    push_word(OP_INPUT,  12'hFFF, 16'h8000, 1'b1, 1'b1);  // ... still starts when marked last
    push_word(OP_UNUSED, 12'd0,   16'h7FFF, 1'b1, 1'b1);  // spare operation does nothing
    push_word(OP_UNUSED, 12'hFFF, 16'h8000, 1'b0, 1'b0);
    push_word(OP_INPUT,  12'd0,   16'h0000, 1'b1, 1'b1);
    push_word(OP_WEIGHT, 12'hFFF, 16'h8000, 1'b0, 1'b0);
    push_word(OP_INPUT,  12'd0,   16'h8000, 1'b1, 1'b1);

    // Random phases, each with fresh counts written while the block is idle
    for (p = 0; p < PHASES; p++) begin
      await_idle();
      write_count_reg(REG_INPUT_COUNT, CFG_W'(phase_ni[p]));
      write_count_reg(REG_NEURON_COUNT, CFG_W'(phase_nn[p]));
      if (p == 2) begin
        // spare register indexes must leave both counts alone
        write_count_reg(REG_SPARE_A, CFG_W'($urandom));
        write_count_reg(REG_SPARE_B, CFG_W'($urandom));
      end
      if (p == PHASES - 1) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else begin
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
      end
      // With sixteen neurons per vector, a long receiver hold-off fills the
      // result register and backs the block up into its input
      if (p == 1) hold_off_len = HOLD_OFF;
      run_phase(phase_budget[p]);
    end

    // Drain: wait for every owed sum, then a short tail for stray words
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.pending() != 0)
      $display("%0d neuron sums never arrived", sb.pending());
    if (sb.bad_sums == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
sv/fcl_pkg.sv
sv/fcl_ifs.sv
sv/fcl_ram.sv
sv/fcl_datapath.sv
sv/fcl_ctrl.sv
sv/fully_connected_layer_top.sv
bench/testbench.sv
